>>> hw/rtl/mts_pkg.sv
`timescale 1ns / 1ps
// Package for the melody tone sequencer: table size, command codes, volume limits
// and the packed word types of the input, result and volume channels. No dependencies.
package mts_pkg;

  // Number of entries in the note table, and the widths that follow from it.
  localparam int MAX_NOTES  = 16;
  localparam int NOTE_IDX_W = $clog2(MAX_NOTES);
  localparam int LEN_W      = $clog2(MAX_NOTES + 1);

  // Command codes of the input word.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Volume limits.
  localparam logic [2:0] VOLUME_MAX   = 3'd5;
  localparam logic [2:0] VOLUME_RESET = 3'd3;
  localparam logic [2:0] VOLUME_MUTE  = 3'd0;

  // Largest elapsed count; the counter holds there.
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // One input word.
  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  note_index;
    logic [15:0] note_freq;
    logic [15:0] note_duration;
    logic [4:0]  melody_length;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic        tone_enable;
    logic [15:0] tone_freq;
    logic        playing;
    logic        finished;
  } out_item_t;

  // Volume register write, as seen by the sequencing core.
  typedef struct packed {
    logic       en;
    logic [2:0] level;
  } vol_write_t;

endpackage

>>> hw/rtl/mts_core.sv
`timescale 1ns / 1ps
// Sequencing core: note tables, playback state and volume register, and the
// single-pass update for one input word. Depends on mts_pkg.
module mts_core
  import mts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_item_t   item,
  input  vol_write_t vol_wr,
  output out_item_t  result
);

  // Note tables, loaded by write commands; no reset.
  logic [15:0] freq_table [MAX_NOTES];
  logic [15:0] dur_table  [MAX_NOTES];

  // Playback state.
  logic [LEN_W-1:0] current_note;
  logic [LEN_W-1:0] active_length;
  logic [15:0]      elapsed_ms;
  logic             busy;
  logic [15:0]      sounding_freq;
  logic [2:0]       volume_level;

  logic [LEN_W-1:0] current_note_next;
  logic [LEN_W-1:0] active_length_next;
  logic [15:0]      elapsed_ms_next;
  logic             busy_next;
  logic [15:0]      sounding_freq_next;
  logic [2:0]       volume_level_next;
  logic             fin;

  logic             wr_en;
  logic [LEN_W-1:0] start_len;
  logic [LEN_W-1:0] next_note;
  logic [15:0]      elapsed_inc;
  logic [15:0]      cur_dur;
  logic [15:0]      next_freq;

  // Helper values for the write, start and tick paths.
  assign wr_en       = step && (item.command == CMD_WRITE) && (int'(item.note_index) < MAX_NOTES);
  assign start_len   = (int'(item.melody_length) > MAX_NOTES) ? LEN_W'(MAX_NOTES)
                                                              : LEN_W'(item.melody_length);
  assign next_note   = current_note + LEN_W'(1);
  assign elapsed_inc = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 16'd1 : elapsed_ms;
  assign cur_dur     = (int'(current_note) < MAX_NOTES)
                       ? dur_table[current_note[NOTE_IDX_W-1:0]] : 16'd0;
  assign next_freq   = (int'(next_note) < MAX_NOTES)
                       ? freq_table[next_note[NOTE_IDX_W-1:0]] : 16'd0;

  // Next-state logic for one command, plus the volume register write.
  always_comb begin
    current_note_next  = current_note;
    active_length_next = active_length;
    elapsed_ms_next    = elapsed_ms;
    busy_next          = busy;
    sounding_freq_next = sounding_freq;
    volume_level_next  = volume_level;
    fin                = 1'b0;

    if (step) begin
      case (item.command)
        CMD_START: begin
          if ((volume_level != VOLUME_MUTE) && (item.melody_length != 5'd0)) begin
            active_length_next = start_len;
            busy_next          = 1'b1;
            current_note_next  = '0;
            elapsed_ms_next    = 16'd0;
            sounding_freq_next = freq_table[0];
          end
        end
        CMD_TICK: begin
          if (busy) begin
            if (elapsed_inc >= cur_dur) begin
              current_note_next = next_note;
              if (next_note >= active_length) begin
                busy_next          = 1'b0;
                sounding_freq_next = 16'd0;
                elapsed_ms_next    = elapsed_inc;
                fin                = 1'b1;
              end else begin
                elapsed_ms_next    = 16'd0;
                sounding_freq_next = next_freq;
              end
            end else begin
              elapsed_ms_next = elapsed_inc;
            end
          end
        end
        default: begin
          // Writes touch only the tables; the unused code does nothing.
        end
      endcase
    end

    // Volume writes saturate; a mute stops the melody at once.
    if (vol_wr.en) begin
      volume_level_next = (vol_wr.level > VOLUME_MAX) ? VOLUME_MAX : vol_wr.level;
      if (vol_wr.level == VOLUME_MUTE) begin
        busy_next          = 1'b0;
        sounding_freq_next = 16'd0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_note  <= '0;
      active_length <= '0;
      elapsed_ms    <= 16'd0;
      busy          <= 1'b0;
      sounding_freq <= 16'd0;
      volume_level  <= VOLUME_RESET;
    end else begin
      current_note  <= current_note_next;
      active_length <= active_length_next;
      elapsed_ms    <= elapsed_ms_next;
      busy          <= busy_next;
      sounding_freq <= sounding_freq_next;
      volume_level  <= volume_level_next;
    end
  end

  // Table writes.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq_table[item.note_index[NOTE_IDX_W-1:0]] <= item.note_freq;
      dur_table[item.note_index[NOTE_IDX_W-1:0]]  <= item.note_duration;
    end
  end

  // Status after this word's update.
  assign result.tone_enable = (sounding_freq_next != 16'd0);
  assign result.tone_freq   = sounding_freq_next;
  assign result.playing     = busy_next;
  assign result.finished    = fin;

endmodule

>>> hw/rtl/melody_tone_sequencer.sv
`timescale 1ns / 1ps
// Top level of the melody tone sequencer: input register, result register and
// the valid/stall handshakes around mts_core. Depends on mts_pkg and mts_core.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_stall    in_data  (in_item_t)
//   out      output     out_valid / out_stall  out_data (out_item_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_data (volume level, 3 bits)
//
// One word is accepted every cycle while in_stall is low; each word gives one result,
// registered first in the input register, then by the core update into the result register.
// The core updates its state for each word in a single combinational pass.
// Synchronous reset clears the handshake and playback state; no clearing pass.
// A stalled result holds the pipe; the input register then holds and in_stall rises if it holds a word.
module melody_tone_sequencer
  import mts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  logic       s1_valid;
  in_item_t   s1_item;
  logic       pipe_move;
  logic       in_take;
  logic       step;
  out_item_t  result;
  vol_write_t vol_wr;

  // Flow control: the pipe moves whenever the result register is free or drained.
  assign pipe_move = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !pipe_move;
  assign in_take   = in_valid && !in_stall;
  assign step      = s1_valid && pipe_move;
  assign cfg_ready = 1'b1;

  assign vol_wr.en    = cfg_valid;
  assign vol_wr.level = cfg_data;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !pipe_move);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= in_data;
    end
  end

  // Sequencing core.
  mts_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .vol_wr (vol_wr),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pipe_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule
